@@ sv/ngs_pkg.sv @@
// ----------------------------------------------------------------------------
// ngs_pkg
// Shared widths, codes and types of the next-greater-element stream block.
// ----------------------------------------------------------------------------
package ngs_pkg;

  localparam int unsigned StackDepth   = 32;
  localparam int unsigned ValueBits    = 16;
  localparam int unsigned PositionBits = 16;
  localparam int unsigned StatusBits   = 2;

  typedef logic [ValueBits-1:0]    value_t;
  typedef logic [PositionBits-1:0] pos_t;
  typedef logic [StatusBits-1:0]   status_t;

  localparam status_t StatusResolved  = 2'd0;
  localparam status_t StatusNoGreater = 2'd1;
  localparam status_t StatusEvicted   = 2'd2;

  // One stack entry as held by a cell.
  typedef struct packed {
    logic   valid;
    pos_t   pos;
    value_t val;
  } entry_t;

  // Shift command broadcast to every cell.
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WORK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

endpackage

@@ sv/ngs_cell.sv @@
// ----------------------------------------------------------------------------
// ngs_cell
// One stack slot. Push takes the entry from the cell above, pop takes the
// entry from the cell below.
// ----------------------------------------------------------------------------
module ngs_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ngs_pkg::cell_op_e op_i,
  input  ngs_pkg::entry_t   upper_i,
  input  ngs_pkg::entry_t   lower_i,
  output ngs_pkg::entry_t   entry_o
);
  import ngs_pkg::*;

  logic   valid_q, valid_d;
  pos_t   pos_q, pos_d;
  value_t val_q, val_d;

  always_comb begin
    valid_d = valid_q;
    pos_d   = pos_q;
    val_d   = val_q;
    case (op_i)
      OP_PUSH: begin
        valid_d = upper_i.valid;
        pos_d   = upper_i.pos;
        val_d   = upper_i.val;
      end
      OP_POP: begin
        valid_d = lower_i.valid;
        pos_d   = lower_i.pos;
        val_d   = lower_i.val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    val_q <= val_d;
  end

  assign entry_o = '{valid: valid_q, pos: pos_q, val: val_q};

endmodule

@@ sv/next_greater_element_stream.sv @@
// ----------------------------------------------------------------------------
// next_greater_element_stream
// Results: pops come first, an eviction comes with the push, and flush results
// follow the push; all leave through the output register, one result per cycle
// while the output slot is free. A new item is taken only in idle. An eviction
// shares the push cycle. A stalled output slot holds the work.
// Reset: stack empty, position counter 0, output register empty.
// ----------------------------------------------------------------------------
module next_greater_element_stream (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ngs_pkg::value_t      sample_value_i,
  input  logic                 end_of_stream_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ngs_pkg::pos_t        position_o,
  output ngs_pkg::pos_t        distance_o,
  output ngs_pkg::status_t     status_o,
  output logic                 last_of_run_o
);
  import ngs_pkg::*;

  // Sequencer state
  state_e   state_q, state_d;
  value_t   val_q;        // value of the item at work
  logic     last_q;       // item closes the stream
  pos_t     pos_q;        // position of the item at work
  pos_t     pos_cnt_q, pos_cnt_d;

  // Stack chain: cell 0 is the top (newest), the last cell the bottom.
  entry_t   cells [StackDepth];
  cell_op_e op;
  entry_t   new_entry;
  entry_t   empty_entry;

  // Output register
  logic     out_valid_q, out_valid_d;
  logic     emit;
  pos_t     emit_pos, emit_dist;
  status_t  emit_status;
  logic     emit_last;
  pos_t     out_pos_q, out_dist_q;
  status_t  out_status_q;
  logic     out_last_q;

  logic     can_emit;
  logic     pop_top, pop_next, full;
  logic     in_xfer;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign new_entry   = '{valid: 1'b1, pos: pos_q, val: val_q};
  assign empty_entry = '{valid: 1'b0, pos: '0, val: '0};

  for (genvar i = 0; i < StackDepth; i++) begin : g_cell
    entry_t upper, lower;
    if (i == 0) begin : g_top
      assign upper = new_entry;
    end else begin : g_mid_up
      assign upper = cells[i-1];
    end
    if (i == StackDepth - 1) begin : g_bot
      assign lower = empty_entry;
    end else begin : g_mid_lo
      assign lower = cells[i+1];
    end
    ngs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (op),
      .upper_i (upper),
      .lower_i (lower),
      .entry_o (cells[i])
    );
  end

  // Output slot is free when empty or being drained this cycle.
  assign can_emit = !out_valid_q || !out_stall_i;

  // Strictly greater pops; the second compare tells whether this pop is the
  // final pop of the run.
  assign pop_top  = cells[0].valid && (val_q > cells[0].val);
  assign pop_next = cells[1].valid && (val_q > cells[1].val);
  assign full     = cells[StackDepth-1].valid;

  always_comb begin
    state_d     = state_q;
    pos_cnt_d   = pos_cnt_q;
    op          = OP_HOLD;
    emit        = 1'b0;
    emit_pos    = cells[0].pos;
    emit_dist   = '0;
    emit_status = StatusResolved;
    emit_last   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d   = ST_WORK;
          pos_cnt_d = end_of_stream_i ? '0 : PositionBits'(pos_cnt_q + 1'b1);
        end
      end
      ST_WORK: begin
        if (pop_top) begin
          if (can_emit) begin
            emit      = 1'b1;
            emit_dist = PositionBits'(pos_q - cells[0].pos);
            emit_last = !pop_next && !last_q;
            op        = OP_POP;
          end
        end else if (full) begin
          // Oldest entry drops off the bottom as the new one is pushed.
          if (can_emit) begin
            emit        = 1'b1;
            emit_pos    = cells[StackDepth-1].pos;
            emit_status = StatusEvicted;
            emit_last   = !last_q;
            op          = OP_PUSH;
            state_d     = last_q ? ST_FLUSH : ST_IDLE;
          end
        end else begin
          op      = OP_PUSH;
          state_d = last_q ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (can_emit) begin
          emit        = 1'b1;
          emit_status = StatusNoGreater;
          emit_last   = !cells[1].valid;
          op          = OP_POP;
          if (!cells[1].valid) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_cnt_q   <= pos_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      val_q  <= sample_value_i;
      last_q <= end_of_stream_i;
      pos_q  <= pos_cnt_q;
    end
    if (emit) begin
      out_pos_q    <= emit_pos;
      out_dist_q   <= emit_dist;
      out_status_q <= emit_status;
      out_last_q   <= emit_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign position_o    = out_pos_q;
  assign distance_o    = out_dist_q;
  assign status_o      = out_status_q;
  assign last_of_run_o = out_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // Occupied cells stay packed against the top (checked on the top two cells).
  a_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cells[1].valid |-> cells[0].valid)
    else $error("stack cells not contiguous");

  // Flush always has an entry at the top to report.
  a_flush_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |-> cells[0].valid)
    else $error("flush with empty stack");

  // An input transfer always starts the compare phase.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_WORK))
    else $error("input transfer did not start work");

  // A result never carries the unused status code.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == StatusResolved || status_o == StatusNoGreater ||
                     status_o == StatusEvicted))
    else $error("illegal status code");

endmodule

@@ sim/tb_next_greater_element_stream.sv @@
// ----------------------------------------------------------------------------
// tb_next_greater_element_stream
// Self-checking bench for the next-greater-element stream unit. A shadow
// monotonic stack predicts every result of each input transfer. The results
// are then compared in order against the result channel. The run covers
// directed corner cases, stack overflow under long output backpressure,
// and random streams with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_next_greater_element_stream;
  timeunit 1ns;
  timeprecision 1ps;

  import ngs_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;  // cycles without any transfer
  localparam int unsigned HoldOffCycles = 250;   // long output stall
  localparam int unsigned MaxReported   = 10;
  localparam int unsigned RandomItems   = 170;

  // One result as seen on the output ports.
  typedef struct {
    pos_t    position;
    pos_t    distance;
    status_t status;
    logic    last_of_run;
  } resolution_t;

  logic    clk_i           = 1'b0;
  logic    rst_ni          = 1'b0;
  logic    in_valid_i      = 1'b0;
  logic    in_stall_o;
  value_t  sample_value_i  = '0;
  logic    end_of_stream_i = 1'b0;
  logic    out_valid_o;
  logic    out_stall_i     = 1'b0;
  pos_t    position_o;
  pos_t    distance_o;
  status_t status_o;
  logic    last_of_run_o;

  always #6 clk_i = ~clk_i;

  next_greater_element_stream dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_value_i (sample_value_i),
    .end_of_stream_i(end_of_stream_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .position_o     (position_o),
    .distance_o     (distance_o),
    .status_o       (status_o),
    .last_of_run_o  (last_of_run_o)
  );

  // --------------------------------------------------------------------------
  // Shadow stack: index 0 is the oldest entry, stk_used - 1 the top.
  // --------------------------------------------------------------------------
  pos_t        stk_pos [StackDepth];
  value_t      stk_val [StackDepth];
  int unsigned stk_used      = 0;
  pos_t        next_position = '0;
  resolution_t pending_resolutions [$];

  int unsigned mismatch_count = 0;
  bit          src_idle_on    = 1'b0;
  bit          sink_idle_on   = 1'b0;
  int unsigned hold_left      = 0;   // long receiver hold-off, counted below
  int unsigned stall_left     = 0;
  int unsigned quiet_cycles   = 0;

  function automatic resolution_t make_resolution(pos_t pos, pos_t gap, status_t st);
    resolution_t r;
    r.position    = pos;
    r.distance    = gap;
    r.status      = st;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // Work out every result caused by one accepted sample, in output order:
  // pops (newest first), then an eviction, then the end-of-stream flush.
  function automatic void resolve_sample(value_t value, logic eos);
    resolution_t run [$];
    pos_t        cur;
    cur = next_position;
    // strictly greater pops; equal values stay on the stack
    while (stk_used != 0 && value > stk_val[stk_used-1]) begin
      run.push_back(make_resolution(stk_pos[stk_used-1], cur - stk_pos[stk_used-1],
                                    StatusResolved));
      stk_used--;
    end
    // still full: drop the bottom entry
    if (stk_used >= StackDepth) begin
      run.push_back(make_resolution(stk_pos[0], '0, StatusEvicted));
      for (int i = 1; i < StackDepth; i++) begin
        stk_pos[i-1] = stk_pos[i];
        stk_val[i-1] = stk_val[i];
      end
      stk_used = StackDepth - 1;
    end
    stk_pos[stk_used] = cur;
    stk_val[stk_used] = value;
    stk_used++;
    // end of stream: everything left has no greater value, counter restarts
    if (eos) begin
      while (stk_used != 0) begin
        run.push_back(make_resolution(stk_pos[stk_used-1], '0, StatusNoGreater));
        stk_used--;
      end
      next_position = '0;
    end else begin
      next_position = cur + 1'b1;   // wraps at the position width
    end
    if (run.size() != 0) run[run.size()-1].last_of_run = 1'b1;
    foreach (run[i]) pending_resolutions.push_back(run[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: every output transfer against the oldest pending result.
  // --------------------------------------------------------------------------
  function automatic void flag_mismatch(string what, resolution_t want, resolution_t got);
    mismatch_count++;
    if (mismatch_count <= MaxReported)
      $display("%0t %s: expected pos=%0d dist=%0d status=%0d last=%0b,",
               $time, what, want.position, want.distance, want.status, want.last_of_run,
               " got pos=%0d dist=%0d status=%0d last=%0b",
               got.position, got.distance, got.status, got.last_of_run);
  endfunction

  always @(posedge clk_i) begin
    resolution_t want;
    resolution_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.position    = position_o;
      got.distance    = distance_o;
      got.status      = status_o;
      got.last_of_run = last_of_run_o;
      if (pending_resolutions.size() == 0) begin
        want = make_resolution('0, '0, StatusResolved);
        flag_mismatch("unexpected result", want, got);
      end else begin
        want = pending_resolutions.pop_front();
        if (got.position !== want.position || got.distance !== want.distance ||
            got.status !== want.status || got.last_of_run !== want.last_of_run)
          flag_mismatch("result mismatch", want, got);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: long hold-off on request, otherwise random stall bursts while
  // sink idling is on.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left = stall_left - 1;
    end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = $urandom_range(0, 10);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog: any transfer on either side restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t watchdog: no transfer for %0d cycles", $time, quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sender side. Called at a rising edge; returns at the edge of the transfer
  // (or after a random gap). Valid stays high when the next item follows.
  // --------------------------------------------------------------------------
  task automatic send_sample(value_t value, logic eos);
    in_valid_i      <= 1'b1;
    sample_value_i  <= value;
    end_of_stream_i <= eos;
    do @(posedge clk_i); while (in_stall_o);
    resolve_sample(value, eos);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // Sender pause until every predicted result has come out.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (pending_resolutions.size() != 0) @(posedge clk_i);
  endtask

  // Extremes of the value, equal values, multi-pops, flush with and without
  // pops, single-item streams.
  task automatic test_directed_cases();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);   // pops the zero, distance 1
    send_sample(16'hFFFF, 1'b0);   // equal: no pop
    send_sample(16'd100, 1'b0);
    send_sample(16'd100, 1'b0);
    send_sample(16'h8000, 1'b0);   // pops both 100s, newest first
    send_sample(16'h0000, 1'b1);   // flush includes the current element
    send_sample(16'd1234, 1'b1);   // one-item stream
    send_sample(16'h0000, 1'b1);
    send_sample(16'd5, 1'b0);
    send_sample(16'd4, 1'b0);
    send_sample(16'd3, 1'b0);
    send_sample(16'd2, 1'b0);
    send_sample(16'd1, 1'b0);
    send_sample(16'd10, 1'b1);     // pops five, then flushes itself
    send_sample(16'hAAAA, 1'b0);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hFFFF, 1'b1);
  endtask

  // Non-rising values overflow the stack while the receiver holds off, so the
  // block backs up into its input; a final max value then pops the full
  // stack and flushes itself (the largest result burst).
  task automatic test_overflow_backpressure();
    wait_for_drain();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    hold_left    = HoldOffCycles;
    for (int i = 0; i < 40; i++) send_sample(value_t'(60000 - (i / 2) * 100), 1'b0);
    send_sample('1, 1'b1);
    wait_for_drain();
  endtask

  // Whole streams of random length and flavor; the last stretch runs with
  // no idling on either side.
  task automatic test_random_streams();
    int unsigned sent;
    int unsigned len;
    int unsigned flavor;
    bit          paused;
    value_t      v;
    sent   = 0;
    paused = 1'b0;
    while (sent < RandomItems) begin
      src_idle_on  = (sent + 30 < RandomItems) && $urandom_range(0, 3) != 0;
      sink_idle_on = (sent + 30 < RandomItems) && $urandom_range(0, 3) != 0;
      flavor       = $urandom_range(0, 3);
      len          = (flavor == 2) ? $urandom_range(33, 40) : $urandom_range(1, 16);
      v            = '1 - value_t'($urandom_range(0, 1000));
      for (int k = 0; k < len; k++) begin
        case (flavor)
          0: v = value_t'($urandom);
          1: v = value_t'($urandom_range(0, 3));                 // many equal values
          2: v = ($urandom_range(0, 7) == 0) ? value_t'($urandom)
                                             : v - value_t'($urandom_range(0, 40));
          default: v = value_t'(16'hFFFF >> $urandom_range(0, 16));
        endcase
        send_sample(v, k == len - 1);
      end
      sent += len;
      if (!paused && sent >= RandomItems / 2) begin
        wait_for_drain();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_overflow_backpressure();
    test_random_streams();
    wait_for_drain();
    // catch stray results after the last expected one
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_resolutions.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ next_greater_element_stream.f @@
sv/ngs_pkg.sv
sv/ngs_cell.sv
sv/next_greater_element_stream.sv
sim/tb_next_greater_element_stream.sv
